### rtl/hidcrb_pkg.sv
// ----------------------------------------------------------------------------
// hidcrb_pkg
// Shared opcodes, report ids, command and report types for the composite
// HID report builder.
// ----------------------------------------------------------------------------
package hidcrb_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    // slots that fit in one keyboard report
    localparam int REPORT_SLOTS  = 6;

    localparam logic [3:0] OP_MOVE          = 4'd0;
    localparam logic [3:0] OP_BUTTONS       = 4'd1;
    localparam logic [3:0] OP_CLICK         = 4'd2;
    localparam logic [3:0] OP_KEY_PRESS     = 4'd3;
    localparam logic [3:0] OP_KEY_RELEASE   = 4'd4;
    localparam logic [3:0] OP_RELEASE_ALL   = 4'd5;
    localparam logic [3:0] OP_KEY_TAP       = 4'd6;
    localparam logic [3:0] OP_MEDIA_PRESS   = 4'd7;
    localparam logic [3:0] OP_MEDIA_RELEASE = 4'd8;
    localparam logic [3:0] OP_MEDIA_TAP     = 4'd9;

    localparam logic [1:0] RID_KEYBOARD = 2'd1;
    localparam logic [1:0] RID_CONSUMER = 2'd2;
    localparam logic [1:0] RID_MOUSE    = 2'd3;

    typedef struct packed {
        logic [3:0]        opcode;
        logic              link_up;
        logic signed [7:0] move_dx;
        logic signed [7:0] move_dy;
        logic signed [7:0] wheel_in;
        logic [7:0]        button_bits;
        logic [7:0]        key_code;
        logic [7:0]        modifier_bits;
        logic [15:0]       media_bits_in;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        report_kind;
        logic [7:0]        lead_byte;
        logic [47:0]       key_slots_out;
        logic signed [7:0] motion_x;
        logic signed [7:0] motion_y;
        logic signed [7:0] wheel_out;
        logic [15:0]       media_bits_out;
        logic              last_report;
    } report_t;

    function automatic report_t kb_report(input logic [7:0] mods,
                                          input logic [47:0] keys,
                                          input logic last);
        report_t r;
        r = '0;
        r.report_kind   = RID_KEYBOARD;
        r.lead_byte     = mods;
        r.key_slots_out = keys;
        r.last_report   = last;
        return r;
    endfunction

    function automatic report_t mouse_report(input logic [7:0] btn,
                                             input logic [7:0] dx,
                                             input logic [7:0] dy,
                                             input logic [7:0] dw,
                                             input logic last);
        report_t r;
        r = '0;
        r.report_kind = RID_MOUSE;
        r.lead_byte   = btn;
        r.motion_x    = dx;
        r.motion_y    = dy;
        r.wheel_out   = dw;
        r.last_report = last;
        return r;
    endfunction

    function automatic report_t media_report(input logic [15:0] media,
                                             input logic last);
        report_t r;
        r = '0;
        r.report_kind    = RID_CONSUMER;
        r.media_bits_out = media;
        r.last_report    = last;
        return r;
    endfunction

endpackage

### rtl/hidcrb_cmd_decode.sv
// ----------------------------------------------------------------------------
// hidcrb_cmd_decode
// Applies one command to the held keyboard, mouse and consumer state and
// forms the zero, one or two reports it causes.
// ----------------------------------------------------------------------------
module hidcrb_cmd_decode
    import hidcrb_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  cmd_t                        cmd_i,
    input  logic [KEY_SLOTS-1:0][7:0]   slot_i,
    input  logic [7:0]                  mods_i,
    input  logic [7:0]                  btn_i,
    input  logic [15:0]                 media_i,
    output logic [KEY_SLOTS-1:0][7:0]   slot_o,
    output logic [7:0]                  mods_o,
    output logic [7:0]                  btn_o,
    output logic [15:0]                 media_o,
    output report_t                     rep0_o,
    output report_t                     rep1_o,
    output logic [1:0]                  rep_count_o
);

    function automatic logic [47:0] pack_keys(input logic [KEY_SLOTS-1:0][7:0] s);
        logic [47:0] v;
        v = '0;
        for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (j < KEY_SLOTS) begin
                v[j*8 +: 8] = s[j];
            end
        end
        return v;
    endfunction

    logic [KEY_SLOTS-1:0]      empty_hit;
    logic [KEY_SLOTS-1:0]      match_hit;
    logic [KEY_SLOTS-1:0]      empty_first;
    logic [KEY_SLOTS-1:0]      match_first;
    logic [KEY_SLOTS-1:0][7:0] press_slots;
    logic [KEY_SLOTS-1:0][7:0] release_slots;
    logic [KEY_SLOTS-1:0][7:0] tap_slots;
    logic [KEY_SLOTS-1:0][7:0] tap_done_slots;
    logic [7:0]                press_mods;

    // first empty slot and first matching slot, lowest index wins
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            empty_hit[i] = (slot_i[i] == 8'h00);
            match_hit[i] = (slot_i[i] == cmd_i.key_code);
        end
        empty_first = empty_hit & ~(empty_hit - 1'b1);
        match_first = match_hit & ~(match_hit - 1'b1);
        for (int i = 0; i < KEY_SLOTS; i++) begin
            press_slots[i]   = empty_first[i] ? cmd_i.key_code : slot_i[i];
            release_slots[i] = match_first[i] ? 8'h00 : slot_i[i];
        end
        tap_slots         = slot_i;
        tap_slots[0]      = cmd_i.key_code;
        tap_done_slots    = slot_i;
        tap_done_slots[0] = 8'h00;
        press_mods        = mods_i | cmd_i.modifier_bits;
    end

    always_comb begin
        slot_o      = slot_i;
        mods_o      = mods_i;
        btn_o       = btn_i;
        media_o     = media_i;
        rep0_o      = '0;
        rep1_o      = '0;
        rep_count_o = 2'd0;
        if (cmd_i.link_up) begin
            unique case (cmd_i.opcode)
                OP_MOVE: begin
                    rep0_o      = mouse_report(btn_i, cmd_i.move_dx, cmd_i.move_dy,
                                               cmd_i.wheel_in, 1'b1);
                    rep_count_o = 2'd1;
                end
                OP_BUTTONS: begin
                    btn_o       = cmd_i.button_bits;
                    rep0_o      = mouse_report(cmd_i.button_bits, '0, '0, '0, 1'b1);
                    rep_count_o = 2'd1;
                end
                OP_CLICK: begin
                    btn_o       = 8'h00;
                    rep0_o      = mouse_report(cmd_i.button_bits, '0, '0, '0, 1'b0);
                    rep1_o      = mouse_report(8'h00, '0, '0, '0, 1'b1);
                    rep_count_o = 2'd2;
                end
                OP_KEY_PRESS: begin
                    // modifiers latch even with every slot taken
                    mods_o = press_mods;
                    if (|empty_hit) begin
                        slot_o      = press_slots;
                        rep0_o      = kb_report(press_mods, pack_keys(press_slots), 1'b1);
                        rep_count_o = 2'd1;
                    end
                end
                OP_KEY_RELEASE: begin
                    if (|match_hit) begin
                        slot_o      = release_slots;
                        rep0_o      = kb_report(mods_i, pack_keys(release_slots), 1'b1);
                        rep_count_o = 2'd1;
                    end
                end
                OP_RELEASE_ALL: begin
                    slot_o      = '0;
                    mods_o      = 8'h00;
                    rep0_o      = kb_report(8'h00, '0, 1'b1);
                    rep_count_o = 2'd1;
                end
                OP_KEY_TAP: begin
                    slot_o      = tap_done_slots;
                    mods_o      = 8'h00;
                    rep0_o      = kb_report(cmd_i.modifier_bits, pack_keys(tap_slots), 1'b0);
                    rep1_o      = kb_report(8'h00, pack_keys(tap_done_slots), 1'b1);
                    rep_count_o = 2'd2;
                end
                OP_MEDIA_PRESS: begin
                    media_o     = cmd_i.media_bits_in;
                    rep0_o      = media_report(cmd_i.media_bits_in, 1'b1);
                    rep_count_o = 2'd1;
                end
                OP_MEDIA_RELEASE: begin
                    media_o     = 16'h0000;
                    rep0_o      = media_report(16'h0000, 1'b1);
                    rep_count_o = 2'd1;
                end
                OP_MEDIA_TAP: begin
                    media_o     = 16'h0000;
                    rep0_o      = media_report(cmd_i.media_bits_in, 1'b0);
                    rep1_o      = media_report(16'h0000, 1'b1);
                    rep_count_o = 2'd2;
                end
                default: begin
                    rep_count_o = 2'd0;
                end
            endcase
        end
    end

endmodule

### rtl/hid_composite_report_builder_unit.sv
// ----------------------------------------------------------------------------
// hid_composite_report_builder_unit
// Composite HID report builder: keyboard (six key slots), consumer control
// and mouse reports from a stream of HID commands.
// ----------------------------------------------------------------------------
// A command beat is taken when the slave side is ready, and its first report
// appears on the master side in the cycle after. Commands that cause one
// report (or none) run at one beat per cycle while the master side does not
// stall; taps and clicks cause two reports, the second waiting in a holding
// register behind the single result register until the first has left. The
// slave side stays ready while the result register is empty or being drained
// and no second report is waiting. Commands with the link down, and unused
// opcodes, are taken and dropped without any report or state change.
module hid_composite_report_builder_unit
    import hidcrb_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // link_up, move_dx, move_dy, wheel_in, button_bits, key_code,
    // modifier_bits, media_bits_in, zero pad
    input  logic [71:0] s_tdata,
    // opcode
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // lead_byte, key_slots_out, motion_x, motion_y, wheel_out, media_bits_out
    output logic [95:0] m_tdata,
    // report_kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    cmd_t                      cmd;
    logic                      accept;
    logic                      pop;

    logic [KEY_SLOTS-1:0][7:0] slot_reg, slot_next;
    logic [7:0]                mods_reg, mods_next;
    logic [7:0]                btn_reg, btn_next;
    logic [15:0]               media_reg, media_next;
    report_t                   out_reg, out_next;
    report_t                   pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      pend_valid_reg, pend_valid_next;

    logic [KEY_SLOTS-1:0][7:0] dec_slot;
    logic [7:0]                dec_mods;
    logic [7:0]                dec_btn;
    logic [15:0]               dec_media;
    report_t                   dec_rep0;
    report_t                   dec_rep1;
    logic [1:0]                dec_count;

    always_comb begin
        cmd.opcode        = s_tuser;
        cmd.link_up       = s_tdata[0];
        cmd.move_dx       = s_tdata[8:1];
        cmd.move_dy       = s_tdata[16:9];
        cmd.wheel_in      = s_tdata[24:17];
        cmd.button_bits   = s_tdata[32:25];
        cmd.key_code      = s_tdata[40:33];
        cmd.modifier_bits = s_tdata[48:41];
        cmd.media_bits_in = s_tdata[64:49];
    end

    hidcrb_cmd_decode #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_decode (
        .cmd_i       (cmd),
        .slot_i      (slot_reg),
        .mods_i      (mods_reg),
        .btn_i       (btn_reg),
        .media_i     (media_reg),
        .slot_o      (dec_slot),
        .mods_o      (dec_mods),
        .btn_o       (dec_btn),
        .media_o     (dec_media),
        .rep0_o      (dec_rep0),
        .rep1_o      (dec_rep1),
        .rep_count_o (dec_count)
    );

    assign pop      = out_valid_reg & m_tready;
    assign s_tready = ~pend_valid_reg & (~out_valid_reg | m_tready);
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        slot_next       = slot_reg;
        mods_next       = mods_reg;
        btn_next        = btn_reg;
        media_next      = media_reg;
        out_next        = out_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        if (accept) begin
            // decoder passes state through unchanged when the beat is dropped
            slot_next       = dec_slot;
            mods_next       = dec_mods;
            btn_next        = dec_btn;
            media_next      = dec_media;
            out_next        = dec_rep0;
            pend_next       = dec_rep1;
            out_valid_next  = (dec_count != 2'd0);
            pend_valid_next = (dec_count == 2'd2);
        end else if (pop) begin
            if (pend_valid_reg) begin
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg       <= '0;
            mods_reg       <= '0;
            btn_reg        <= '0;
            media_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            slot_reg       <= slot_next;
            mods_reg       <= mods_next;
            btn_reg        <= btn_next;
            media_reg      <= media_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.report_kind;
    assign m_tlast  = out_reg.last_report;
    assign m_tdata  = {out_reg.media_bits_out, out_reg.wheel_out, out_reg.motion_y,
                       out_reg.motion_x, out_reg.key_slots_out, out_reg.lead_byte};

endmodule

### bench/tb_hid_composite_report_builder_unit.sv
// ----------------------------------------------------------------------------
// tb_hid_composite_report_builder_unit
// Self-checking bench for the composite HID report builder. A directed table
// covers extremes, every command and the slot corner cases, then a long
// random run leans on key press and release sequences. Every report is
// checked against the table's own expected reports or an in-bench model of
// slots, modifiers, buttons and media. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_hid_composite_report_builder_unit;
    import hidcrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SLOT_COUNT    = KEY_SLOTS_DEF;
    localparam int         RANDOM_ITEMS  = 1650;
    localparam int         FROM_MODEL    = -1;
    localparam int         MAX_SHOWN     = 10;
    localparam int         DRAIN_CYCLES  = 20;
    localparam logic [3:0] OP_UNUSED_LO  = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI  = 4'd15;
    localparam report_t    NO_REPORT     = '0;

    typedef struct {
        cmd_t    cmd;
        int      typed_count;
        report_t first;
        report_t second;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // link_up, move_dx, move_dy, wheel_in, button_bits, key_code,
    // modifier_bits, media_bits_in, zero pad
    logic [71:0] s_tdata  = '0;
    // opcode
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // lead_byte, key_slots_out, motion_x, motion_y, wheel_out, media_bits_out
    logic [95:0] m_tdata;
    // report_kind
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // model state
    logic [7:0]  held_keys [SLOT_COUNT];
    logic [7:0]  mod_state;
    logic [7:0]  button_state;
    logic [15:0] media_state;
    report_t     step_reports [2];

    report_t     pending_reports [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    bit          quiet_mode [2];

    hid_composite_report_builder_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic report_t mk_report(input logic [1:0] id, input logic [7:0] lead,
                                          input logic [47:0] keys, input logic [7:0] mx,
                                          input logic [7:0] my, input logic [7:0] mw,
                                          input logic [15:0] media, input logic last);
        report_t r;
        r.report_kind    = id;
        r.lead_byte      = lead;
        r.key_slots_out  = keys;
        r.motion_x       = mx;
        r.motion_y       = my;
        r.wheel_out      = mw;
        r.media_bits_out = media;
        r.last_report    = last;
        return r;
    endfunction

    function automatic cmd_t mk_cmd(input logic [3:0] op, input logic link,
                                    input logic [7:0] dx, input logic [7:0] dy,
                                    input logic [7:0] dw, input logic [7:0] btn,
                                    input logic [7:0] key, input logic [7:0] mods,
                                    input logic [15:0] media);
        cmd_t c;
        c.opcode        = op;
        c.link_up       = link;
        c.move_dx       = dx;
        c.move_dy       = dy;
        c.wheel_in      = dw;
        c.button_bits   = btn;
        c.key_code      = key;
        c.modifier_bits = mods;
        c.media_bits_in = media;
        return c;
    endfunction

    function automatic report_t keyboard_snapshot(input logic last);
        logic [47:0] keys;
        keys = '0;
        for (int i = 0; i < SLOT_COUNT && i < REPORT_SLOTS; i++) begin
            keys[8*i +: 8] = held_keys[i];
        end
        return mk_report(RID_KEYBOARD, mod_state, keys, 8'h00, 8'h00, 8'h00, 16'h0000, last);
    endfunction

    function automatic report_t mouse_snapshot(input logic [7:0] dx, input logic [7:0] dy,
                                               input logic [7:0] dw, input logic last);
        return mk_report(RID_MOUSE, button_state, 48'h0, dx, dy, dw, 16'h0000, last);
    endfunction

    function automatic report_t consumer_snapshot(input logic last);
        return mk_report(RID_CONSUMER, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, media_state, last);
    endfunction

    // updates the held state for one command and leaves its reports in step_reports
    function automatic int apply_command(input cmd_t c);
        int n;
        bit hit;
        n   = 0;
        hit = 1'b0;
        if (c.link_up) begin
            case (c.opcode)
                OP_MOVE: begin
                    step_reports[0] = mouse_snapshot(c.move_dx, c.move_dy, c.wheel_in, 1'b1);
                    n = 1;
                end
                OP_BUTTONS: begin
                    button_state    = c.button_bits;
                    step_reports[0] = mouse_snapshot(8'h00, 8'h00, 8'h00, 1'b1);
                    n = 1;
                end
                OP_CLICK: begin
                    button_state    = c.button_bits;
                    step_reports[0] = mouse_snapshot(8'h00, 8'h00, 8'h00, 1'b0);
                    button_state    = 8'h00;
                    step_reports[1] = mouse_snapshot(8'h00, 8'h00, 8'h00, 1'b1);
                    n = 2;
                end
                OP_KEY_PRESS: begin
                    // modifiers stick even when every slot is taken
                    mod_state = mod_state | c.modifier_bits;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!hit && held_keys[i] == 8'h00) begin
                            held_keys[i] = c.key_code;
                            hit = 1'b1;
                        end
                    end
                    if (hit) begin
                        step_reports[0] = keyboard_snapshot(1'b1);
                        n = 1;
                    end
                end
                OP_KEY_RELEASE: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!hit && held_keys[i] == c.key_code) begin
                            held_keys[i] = 8'h00;
                            hit = 1'b1;
                        end
                    end
                    if (hit) begin
                        step_reports[0] = keyboard_snapshot(1'b1);
                        n = 1;
                    end
                end
                OP_RELEASE_ALL: begin
                    mod_state = 8'h00;
                    for (int i = 0; i < SLOT_COUNT; i++) held_keys[i] = 8'h00;
                    step_reports[0] = keyboard_snapshot(1'b1);
                    n = 1;
                end
                OP_KEY_TAP: begin
                    mod_state       = c.modifier_bits;
                    held_keys[0]    = c.key_code;
                    step_reports[0] = keyboard_snapshot(1'b0);
                    mod_state       = 8'h00;
                    held_keys[0]    = 8'h00;
                    step_reports[1] = keyboard_snapshot(1'b1);
                    n = 2;
                end
                OP_MEDIA_PRESS: begin
                    media_state     = c.media_bits_in;
                    step_reports[0] = consumer_snapshot(1'b1);
                    n = 1;
                end
                OP_MEDIA_RELEASE: begin
                    media_state     = 16'h0000;
                    step_reports[0] = consumer_snapshot(1'b1);
                    n = 1;
                end
                OP_MEDIA_TAP: begin
                    media_state     = c.media_bits_in;
                    step_reports[0] = consumer_snapshot(1'b0);
                    media_state     = 16'h0000;
                    step_reports[1] = consumer_snapshot(1'b1);
                    n = 2;
                end
                default: n = 0;
            endcase
        end
        return n;
    endfunction

    // per-item wait, with runs of back-to-back beats now and then
    function automatic int draw_wait(input int side);
        if ($urandom_range(0, 29) == 0) quiet_mode[side] = ~quiet_mode[side];
        return quiet_mode[side] ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        int   key_pick;
        c = mk_cmd(4'($urandom_range(0, 15)), $urandom_range(0, 19) != 0, 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 28)      c.opcode = OP_KEY_PRESS;
        else if (pick < 48) c.opcode = OP_KEY_RELEASE;
        else if (pick < 53) c.opcode = OP_RELEASE_ALL;
        else if (pick < 61) c.opcode = OP_KEY_TAP;
        else if (pick < 67) c.opcode = OP_MOVE;
        else if (pick < 73) c.opcode = OP_BUTTONS;
        else if (pick < 78) c.opcode = OP_CLICK;
        else if (pick < 84) c.opcode = OP_MEDIA_PRESS;
        else if (pick < 88) c.opcode = OP_MEDIA_RELEASE;
        else if (pick < 94) c.opcode = OP_MEDIA_TAP;
        else                c.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        // mostly keys already held, so releases match and presses collide
        key_pick = $urandom_range(0, 9);
        if (key_pick < 6)      c.key_code = held_keys[$urandom_range(0, SLOT_COUNT - 1)];
        else if (key_pick < 8) c.key_code = 8'($urandom_range(0, 8));
        if ($urandom_range(0, 3) == 0) c.modifier_bits = 8'h01 << $urandom_range(0, 7);
        return c;
    endfunction

    task automatic add_row(input cmd_t c, input int typed_count, input report_t first,
                           input report_t second);
        stim_row_t row;
        row.cmd         = c;
        row.typed_count = typed_count;
        row.first       = first;
        row.second      = second;
        directed_rows.push_back(row);
    endtask

    task automatic send_command(input cmd_t c, input int typed_count, input report_t first,
                                input report_t second);
        int wait_cycles;
        int n;
        wait_cycles = draw_wait(0);
        if (wait_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (wait_cycles) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.opcode;
        s_tdata  <= {7'b0, c.media_bits_in, c.modifier_bits, c.key_code, c.button_bits,
                     c.wheel_in, c.move_dy, c.move_dx, c.link_up};
        do @(posedge aclk); while (!s_tready);
        n = apply_command(c);
        if (typed_count == FROM_MODEL) begin
            for (int i = 0; i < n; i++) pending_reports.push_back(step_reports[i]);
        end else begin
            if (typed_count > 0) pending_reports.push_back(first);
            if (typed_count > 1) pending_reports.push_back(second);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        report_t got;
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = mk_report(m_tuser, m_tdata[7:0], m_tdata[55:8], m_tdata[63:56],
                            m_tdata[71:64], m_tdata[79:72], m_tdata[95:80], m_tlast);
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected report: id %0d lead %h keys %h x %h y %h w %h media %h last %b",
                             got.report_kind, got.lead_byte, got.key_slots_out, got.motion_x,
                             got.motion_y, got.wheel_out, got.media_bits_out, got.last_report);
            end else begin
                want = pending_reports.pop_front();
                if (got.report_kind !== want.report_kind || got.lead_byte !== want.lead_byte ||
                    got.key_slots_out !== want.key_slots_out ||
                    got.motion_x !== want.motion_x || got.motion_y !== want.motion_y ||
                    got.wheel_out !== want.wheel_out ||
                    got.media_bits_out !== want.media_bits_out ||
                    got.last_report !== want.last_report) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("report mismatch at %0t", $realtime);
                        $display("  expected: id %0d lead %h keys %h x %h y %h w %h media %h last %b",
                                 want.report_kind, want.lead_byte, want.key_slots_out,
                                 want.motion_x, want.motion_y, want.wheel_out,
                                 want.media_bits_out, want.last_report);
                        $display("  actual:   id %0d lead %h keys %h x %h y %h w %h media %h last %b",
                                 got.report_kind, got.lead_byte, got.key_slots_out, got.motion_x,
                                 got.motion_y, got.wheel_out, got.media_bits_out,
                                 got.last_report);
                    end
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(1);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #6_000_000;
        $display("hid_composite_report_builder_unit regression: fail");
        $finish;
    end

    initial begin
        int   sent;
        cmd_t c;
        sent = 0;
        mod_state    = 8'h00;
        button_state = 8'h00;
        media_state  = 16'h0000;
        for (int i = 0; i < SLOT_COUNT; i++) held_keys[i] = 8'h00;

        // motion and button extremes
        add_row(mk_cmd(OP_MOVE, 1, 8'h7F, 8'h80, 8'hFF, 0, 0, 0, 0), 1,
                mk_report(RID_MOUSE, 8'h00, 48'h0, 8'h7F, 8'h80, 8'hFF, 16'h0, 1'b1),
                NO_REPORT);
        add_row(mk_cmd(OP_BUTTONS, 1, 0, 0, 0, 8'hFF, 0, 0, 0), 1,
                mk_report(RID_MOUSE, 8'hFF, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0, 1'b1),
                NO_REPORT);
        add_row(mk_cmd(OP_MOVE, 1, 8'h80, 8'h7F, 8'h7F, 0, 0, 0, 0), 1,
                mk_report(RID_MOUSE, 8'hFF, 48'h0, 8'h80, 8'h7F, 8'h7F, 16'h0, 1'b1),
                NO_REPORT);
        add_row(mk_cmd(OP_CLICK, 1, 0, 0, 0, 8'h5A, 0, 0, 0), 2,
                mk_report(RID_MOUSE, 8'h5A, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0, 1'b0),
                mk_report(RID_MOUSE, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0, 1'b1));
        // link down and unused opcode are dropped
        add_row(mk_cmd(OP_KEY_PRESS, 0, 0, 0, 0, 0, 8'h04, 8'hFF, 0), 0, NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_UNUSED_HI, 1, 0, 0, 0, 0, 8'h04, 8'hFF, 0), 0, NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'h04, 8'h02, 0), 1,
                mk_report(RID_KEYBOARD, 8'h02, 48'h04, 8'h00, 8'h00, 8'h00, 16'h0, 1'b1),
                NO_REPORT);
        // fill every slot, then press with none free
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'h05, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'h06, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'h07, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'hFF, 8'h40, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'h08, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'h09, 8'h80, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        // release with no match, then a match
        add_row(mk_cmd(OP_KEY_RELEASE, 1, 0, 0, 0, 0, 8'h77, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_RELEASE, 1, 0, 0, 0, 0, 8'h06, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        // key code zero fills and matches an empty slot
        add_row(mk_cmd(OP_KEY_PRESS, 1, 0, 0, 0, 0, 8'h00, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_RELEASE, 1, 0, 0, 0, 0, 8'h00, 8'h00, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_KEY_TAP, 1, 0, 0, 0, 0, 8'hE0, 8'h11, 0), FROM_MODEL,
                NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_RELEASE_ALL, 1, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_report(RID_KEYBOARD, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0, 1'b1),
                NO_REPORT);
        add_row(mk_cmd(OP_KEY_RELEASE, 1, 0, 0, 0, 0, 8'h00, 8'h00, 0), 1,
                mk_report(RID_KEYBOARD, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0, 1'b1),
                NO_REPORT);
        add_row(mk_cmd(OP_MEDIA_PRESS, 1, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1,
                mk_report(RID_CONSUMER, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1),
                NO_REPORT);
        add_row(mk_cmd(OP_MEDIA_RELEASE, 1, 0, 0, 0, 0, 0, 0, 16'h1234), 1,
                mk_report(RID_CONSUMER, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1),
                NO_REPORT);
        add_row(mk_cmd(OP_MEDIA_TAP, 1, 0, 0, 0, 0, 0, 0, 16'h8001), 2,
                mk_report(RID_CONSUMER, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, 16'h8001, 1'b0),
                mk_report(RID_CONSUMER, 8'h00, 48'h0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1));
        add_row(mk_cmd(OP_MEDIA_PRESS, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, NO_REPORT, NO_REPORT);
        add_row(mk_cmd(OP_UNUSED_LO, 1, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, NO_REPORT, NO_REPORT);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].cmd, directed_rows[i].typed_count,
                         directed_rows[i].first, directed_rows[i].second);
        end

        while (sent < RANDOM_ITEMS) begin
            c = random_command();
            sent++;
            send_command(c, FROM_MODEL, NO_REPORT, NO_REPORT);
        end
        s_tvalid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("hid_composite_report_builder_unit regression: pass");
        end else begin
            $display("hid_composite_report_builder_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/hidcrb_pkg.sv
rtl/hidcrb_cmd_decode.sv
rtl/hid_composite_report_builder_unit.sv
bench/tb_hid_composite_report_builder_unit.sv
